FILE: rtl/core/tts_pkg.sv
package tts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TICK_MS_DEF   = 10;
  localparam int RESULT_CAP    = 16;

  localparam int ID_W   = 8;
  localparam int MS_W   = 24;
  localparam int SLOT_W = 4;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;
  localparam logic [1:0] OP_DELETE   = 2'd3;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_RUN     = 2'd2;
  localparam logic [1:0] ST_DELETED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [MS_W-1:0] cd;
    logic [MS_W-1:0] rl;
  } entry_t;

endpackage

FILE: rtl/core/tts_in_if.sv
interface tts_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [tts_pkg::ID_W-1:0]   task_id;
  logic [tts_pkg::MS_W-1:0]   delay_ms;
  logic [tts_pkg::MS_W-1:0]   period_ms;
  logic [tts_pkg::SLOT_W-1:0] slot;

  modport source (output valid, op, task_id, delay_ms, period_ms, slot, input ready);
  modport sink (input valid, op, task_id, delay_ms, period_ms, slot, output ready);
endinterface

FILE: rtl/core/tts_out_if.sv
interface tts_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [tts_pkg::SLOT_W-1:0] where;
  logic [tts_pkg::ID_W-1:0]   task_out;
  logic                      last;

  modport source (output valid, status, where, task_out, last, input ready);
  modport sink (input valid, status, where, task_out, last, output ready);
endinterface

FILE: rtl/core/tick_task_scheduler_table_unit.sv
// Task scheduler table: MAX_TASKS slots whose id, countdown and reload live in one
// synchronous memory, with used and ready marks in flip-flops. One request at a time.
// Add runs the reciprocal multiply by 1/TICK_MS, then a result state; delete goes
// straight there. Tick does one slot read-modify-write per cycle. Dispatch scans one
// slot per cycle, stalling while a held result waits on a busy output; each
// task run shifts later entries up one per cycle; at most 16 results per dispatch.
module tick_task_scheduler_table_unit #(
  parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF,
  parameter int TICK_MS   = tts_pkg::TICK_MS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tts_in_if.sink    in_req,
  tts_out_if.source out_res
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int MW = tts_pkg::MS_W;
  localparam int TW = tts_pkg::ID_W;
  localparam int SW = tts_pkg::SLOT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_OUT   = 4'd2;
  localparam logic [3:0] S_TICK  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_GET   = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_READD = 4'd7;
  localparam logic [3:0] S_END   = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [MAX_TASKS-1:0] used_r, used_nxt, rdy_r, rdy_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [IW-1:0]        sh_r, sh_nxt;
  logic [4:0]           n_r, n_nxt;
  logic [TW-1:0]        tid_r, tid_nxt;
  logic [MW-1:0]        tper_r, tper_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [SW-1:0]        pend_where_r, pend_where_nxt;
  logic [TW-1:0]        pend_id_r, pend_id_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [SW-1:0]        res_where_r, res_where_nxt;
  logic [TW-1:0]        res_id_r, res_id_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [SW-1:0]        out_where_r, out_where_nxt;
  logic [TW-1:0]        out_id_r, out_id_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  tts_pkg::entry_t      mem_wdata, mem_rdata;

  logic                 div_start, div_done, dd, dp;
  logic [MW-1:0]        qd, qp;

  logic                 in_fire, out_free, full;
  logic [IW-1:0]        free_idx, i_idx;
  logic [MAX_TASKS-1:0] ushift, rshift;

  tts_div #(.W(MW), .DIVISOR(TICK_MS)) u_div_dly (
    .clk(clk), .rst_n(rst_n), .start(div_start), .din(in_req.delay_ms), .quo(qd), .done(dd)
  );

  tts_div #(.W(MW), .DIVISOR(TICK_MS)) u_div_per (
    .clk(clk), .rst_n(rst_n), .start(div_start), .din(in_req.period_ms), .quo(qp), .done(dp)
  );

  tts_mem #(.DEPTH(MAX_TASKS), .AW(IW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign div_done = dd & dp;
  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign full     = &used_r;
  assign i_idx    = i_r[IW-1:0];
  assign ushift   = used_r >> 1;
  assign rshift   = rdy_r >> 1;

  always_comb begin
    free_idx = '0;
    for (int j = MAX_TASKS - 1; j >= 0; j--) begin
      if (!used_r[j]) begin
        free_idx = IW'(j);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    rdy_nxt        = rdy_r;
    i_nxt          = i_r;
    sh_nxt         = sh_r;
    n_nxt          = n_r;
    tid_nxt        = tid_r;
    tper_nxt       = tper_r;
    pend_v_nxt     = pend_v_r;
    pend_where_nxt = pend_where_r;
    pend_id_nxt    = pend_id_r;
    res_status_nxt = res_status_r;
    res_where_nxt  = res_where_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_status_nxt = out_status_r;
    out_where_nxt  = out_where_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_req.op)
            tts_pkg::OP_ADD: begin
              div_start = 1'b1;
              tid_nxt   = in_req.task_id;
              state_nxt = S_DIV;
            end
            tts_pkg::OP_TICK: begin
              mem_re    = 1'b1;
              i_nxt     = '0;
              state_nxt = S_TICK;
            end
            tts_pkg::OP_DISPATCH: begin
              i_nxt      = '0;
              n_nxt      = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
            tts_pkg::OP_DELETE: begin
              if (int'(in_req.slot) < MAX_TASKS) begin
                used_nxt[IW'(in_req.slot)] = 1'b0;
                rdy_nxt[IW'(in_req.slot)]  = 1'b0;
              end
              res_status_nxt = tts_pkg::ST_DELETED;
              res_where_nxt  = in_req.slot;
              res_id_nxt     = '0;
              state_nxt      = S_OUT;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (full) begin
            res_status_nxt = tts_pkg::ST_FULL;
            res_where_nxt  = '0;
          end else begin
            mem_we             = 1'b1;
            mem_waddr          = free_idx;
            mem_wdata.id       = tid_r;
            mem_wdata.cd       = qd;
            mem_wdata.rl       = qp;
            used_nxt[free_idx] = 1'b1;
            rdy_nxt[free_idx]  = 1'b0;
            res_status_nxt     = tts_pkg::ST_ADDED;
            res_where_nxt      = SW'(free_idx);
          end
          res_id_nxt = tid_r;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_where_nxt  = res_where_r;
          out_id_nxt     = res_id_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_TICK: begin
        if (used_r[i_idx]) begin
          mem_we    = 1'b1;
          mem_waddr = i_idx;
          if (mem_rdata.cd == '0) begin
            rdy_nxt[i_idx] = 1'b1;
            mem_wdata.cd   = mem_rdata.rl;
          end else begin
            mem_wdata.cd = mem_rdata.cd - MW'(1);
          end
        end
        if (i_r == CW'(MAX_TASKS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(i_r + CW'(1));
          i_nxt     = i_r + CW'(1);
        end
      end
      S_SCAN: begin
        if (i_r == CW'(MAX_TASKS) || n_r == 5'(tts_pkg::RESULT_CAP)) begin
          state_nxt = S_END;
        end else if (used_r[i_idx] && rdy_r[i_idx]) begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = tts_pkg::ST_RUN;
              out_where_nxt  = pend_where_r;
              out_id_nxt     = pend_id_r;
              out_last_nxt   = 1'b0;
            end
            mem_re    = 1'b1;
            mem_raddr = i_idx;
            n_nxt     = n_r + 5'd1;
            state_nxt = S_GET;
          end
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      S_GET: begin
        tid_nxt        = mem_rdata.id;
        tper_nxt       = mem_rdata.rl;
        pend_v_nxt     = 1'b1;
        pend_where_nxt = SW'(i_r);
        pend_id_nxt    = mem_rdata.id;
        for (int j = 0; j < MAX_TASKS; j++) begin
          if (j >= int'(i_r)) begin
            used_nxt[j] = ushift[j];
            rdy_nxt[j]  = rshift[j];
          end
        end
        if (i_r == CW'(MAX_TASKS - 1)) begin
          state_nxt = S_READD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(i_r + CW'(1));
          sh_nxt    = i_idx;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = sh_r;
        mem_wdata = mem_rdata;
        if (sh_r == IW'(MAX_TASKS - 2)) begin
          state_nxt = S_READD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(sh_r + IW'(2));
          sh_nxt    = sh_r + IW'(1);
        end
      end
      S_READD: begin
        if (tper_r != '0) begin
          mem_we             = 1'b1;
          mem_waddr          = free_idx;
          mem_wdata.id       = tid_r;
          mem_wdata.cd       = tper_r;
          mem_wdata.rl       = tper_r;
          used_nxt[free_idx] = 1'b1;
          rdy_nxt[free_idx]  = 1'b0;
        end
        state_nxt = S_SCAN;
      end
      S_END: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = tts_pkg::ST_RUN;
          out_where_nxt  = pend_where_r;
          out_id_nxt     = pend_id_r;
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      rdy_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rdy_r       <= rdy_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    sh_r         <= sh_nxt;
    tid_r        <= tid_nxt;
    tper_r       <= tper_nxt;
    pend_where_r <= pend_where_nxt;
    pend_id_r    <= pend_id_nxt;
    res_status_r <= res_status_nxt;
    res_where_r  <= res_where_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_where_r  <= out_where_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.status   = out_status_r;
  assign out_res.where    = out_where_r;
  assign out_res.task_out = out_id_r;
  assign out_res.last     = out_last_r;

  a_ready_needs_used: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_r & ~used_r) == '0)
    else $error("ready mark on an unused slot");

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same entry in one cycle");

  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 5'(tts_pkg::RESULT_CAP))
    else $error("dispatch result count beyond cap");

  a_readd_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READD && tper_r != '0) |-> !used_r[MAX_TASKS-1])
    else $error("no free slot for periodic re-add");

endmodule

FILE: rtl/core/tts_div.sv
module tts_div #(
  parameter int W       = tts_pkg::MS_W,
  parameter int DIVISOR = tts_pkg::TICK_MS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] din,
  output logic [W-1:0] quo,
  output logic         done
);

  // quotient by multiply with a rounded-up reciprocal, exact for all W-bit inputs
  localparam int SH = W + $clog2(DIVISOR);
  localparam int PW = SH + W;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [W:0] RECIP_W = (W+1)'(RECIP);

  logic [W-1:0]  q_r;
  logic          done_r;
  logic [PW-1:0] prod;

  assign prod = PW'(din) * PW'(RECIP_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
      if (start) begin
        q_r <= prod[PW-1 -: W];
      end
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

FILE: rtl/core/tts_mem.sv
module tts_mem #(
  parameter int DEPTH = tts_pkg::MAX_TASKS_DEF,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tts_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output tts_pkg::entry_t rdata
);

  tts_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
